### sv/ialu_pkg.sv
// Package for the integer ALU with gcd and lcm: widths, command and status codes,
// and sequencer state type. No dependencies.
`default_nettype none
package ialu_pkg;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2,
    CMD_DIV = 3'd3, CMD_GCD = 3'd4, CMD_LCM = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_NONPOS = 3'd2,
    ST_UNKNOWN = 3'd3, ST_LCM_OVF = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_GCD, S_LCMDIV, S_LCMMUL, S_DONE
  } state_t;
endpackage
`default_nettype wire

### sv/integer_alu_with_gcd_lcm.sv
// Integer ALU with gcd and lcm: top level with its sequencer and one shared
// shift/subtract datapath. Depends on ialu_pkg.
`default_nettype none
// Add and subtract are computed when the command is accepted. Multiply and
// divide each take one shift-add or shift-subtract step per operand bit (32
// steps). Gcd runs Euclid, each remainder through the same 32-step divider.
// Lcm is gcd, then a/gcd by the divider, then a 32-step multiply with an
// overflow check. The block takes a new item only after the previous result
// has been taken.
module integer_alu_with_gcd_lcm import ialu_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] in_operand_b,
  input  wire logic [2:0]                   in_command,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_result_value,
  output logic [2:0]                        out_status
);
  localparam int unsigned W = DATA_WIDTH;

  state_t         state_r, state_nxt;
  logic [W-1:0]   a_r, a_nxt;      // original a (lcm)
  logic [W-1:0]   b_r, b_nxt;      // original b / multiplicand
  logic [W-1:0]   x_r, x_nxt;      // dividend/quotient or multiplier shift
  logic [W-1:0]   y_r, y_nxt;      // divisor
  logic [W:0]     rem_r, rem_nxt;  // partial remainder or widened lcm product
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           neg_r, neg_nxt;
  logic           ovf_r, ovf_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic [2:0]     st_r, st_nxt;

  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     shifted, diff;   // shared shift/subtract unit
  logic [W:0]     addsum;
  logic [W:0]     maxpos;

  assign mag_a = in_operand_a[W-1] ? (~in_operand_a + 1'b1) : in_operand_a;
  assign mag_b = in_operand_b[W-1] ? (~in_operand_b + 1'b1) : in_operand_b;
  assign maxpos = {2'b00, {(W-1){1'b1}}};

  // Divide steps share one subtractor (remainder minus divisor), and both
  // multiply loops share one adder (product doubled plus multiplicand).
  assign shifted = {rem_r[W-1:0], x_r[W-1]};
  assign diff    = shifted - {1'b0, y_r};
  assign addsum  = {1'b0, res_r[W-2:0], 1'b0} + {1'b0, b_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command) inside
            CMD_MUL: state_nxt = S_MUL;
            CMD_DIV: state_nxt = (in_operand_b == '0) ? S_DONE : S_DIV;
            CMD_GCD, CMD_LCM: begin
              if (in_operand_a[W-1] || in_operand_b[W-1] ||
                  in_operand_a == '0 || in_operand_b == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_GCD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL:    if (cnt_r == CNT_W'(W - 1)) state_nxt = S_DONE;
      S_DIV:    if (cnt_r == CNT_W'(W - 1)) state_nxt = S_DONE;
      S_GCD: begin
        if (cnt_r == CNT_W'(W - 1)) begin
          // Remainder of this round is diff or shifted, picked below.
          if ((diff[W] ? shifted : diff) == '0) begin
            state_nxt = (st_r == ST_NONPOS) ? S_LCMDIV : S_DONE;
          end
        end
      end
      S_LCMDIV: if (cnt_r == CNT_W'(W - 1)) state_nxt = S_LCMMUL;
      S_LCMMUL: if (cnt_r == CNT_W'(W - 1)) state_nxt = S_DONE;
      S_DONE:   if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; x_nxt = x_r; y_nxt = y_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; neg_nxt = neg_r; ovf_nxt = ovf_r;
    res_nxt = res_r; st_nxt = st_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        rem_nxt = '0;
        a_nxt   = in_operand_a;
        st_nxt  = ST_OK;
        res_nxt = '0;
        unique case (in_command) inside
          CMD_ADD: res_nxt = in_operand_a + in_operand_b;
          CMD_SUB: res_nxt = in_operand_a - in_operand_b;
          CMD_MUL: begin
            b_nxt = in_operand_a;
            x_nxt = in_operand_b;
          end
          CMD_DIV: begin
            if (in_operand_b == '0) st_nxt = ST_DIV0;
            x_nxt   = mag_a;
            y_nxt   = mag_b;
            neg_nxt = in_operand_a[W-1] ^ in_operand_b[W-1];
          end
          CMD_GCD, CMD_LCM: begin
            x_nxt = in_operand_a;
            y_nxt = in_operand_b;
            b_nxt = in_operand_b;
            if (in_operand_a[W-1] || in_operand_b[W-1] ||
                in_operand_a == '0 || in_operand_b == '0) begin
              st_nxt = ST_NONPOS;
              res_nxt = '0;
            end else if (in_command == CMD_LCM) begin
              // Mark lcm in flight; replaced by ok or lcm overflow before the result.
              st_nxt = ST_NONPOS;
            end
          end
          default: st_nxt = ST_UNKNOWN;
        endcase
      end
      S_MUL: begin
        // Left to right: product = product*2 + (bit ? b : 0), low W bits.
        cnt_nxt = cnt_r + 1'b1;
        x_nxt   = {x_r[W-2:0], 1'b0};
        res_nxt = x_r[W-1] ? addsum[W-1:0] : {res_r[W-2:0], 1'b0};
      end
      S_DIV, S_GCD, S_LCMDIV: begin
        // Restoring division step; quotient bits shift into x.
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = diff[W] ? shifted : diff;
        x_nxt   = {x_r[W-2:0], ~diff[W]};
        if (cnt_r == CNT_W'(W - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          if (state_r == S_DIV) begin
            res_nxt = neg_r ? (~{x_r[W-2:0], ~diff[W]} + 1'b1)
                            : {x_r[W-2:0], ~diff[W]};
          end else if (state_r == S_GCD) begin
            if ((diff[W] ? shifted : diff) == '0) begin
              // y holds the gcd; set up a / gcd for lcm.
              res_nxt = y_r;
              x_nxt   = a_r;
            end else begin
              x_nxt = y_r;
              y_nxt = (diff[W] ? shifted[W-1:0] : diff[W-1:0]);
            end
          end else begin
            // Quotient a/g goes to x as multiplier, product from zero.
            res_nxt = '0;
            x_nxt   = {x_r[W-2:0], ~diff[W]};
          end
        end
      end
      S_LCMMUL: begin
        // Exact shift-add of q*b with overflow tracking above maxpos.
        cnt_nxt = cnt_r + 1'b1;
        x_nxt   = {x_r[W-2:0], 1'b0};
        if (res_r[W-1] || res_r[W-2]) begin
          if (x_r[W-1] || (x_r[W-2:0] != '0)) ovf_nxt = 1'b1;
        end
        rem_nxt = x_r[W-1] ? addsum : {1'b0, res_r[W-2:0], 1'b0};
        if (rem_nxt > maxpos) ovf_nxt = 1'b1;
        res_nxt = rem_nxt[W-1:0];
        if (cnt_r == CNT_W'(W - 1)) begin
          if (ovf_nxt) begin
            st_nxt = ST_LCM_OVF;
            res_nxt = '0;
          end else begin
            st_nxt = ST_OK;
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; x_r <= x_nxt; y_r <= y_nxt; rem_r <= rem_nxt;
    cnt_r <= cnt_nxt; neg_r <= neg_nxt; ovf_r <= ovf_nxt;
    res_r <= res_nxt; st_r <= st_nxt;
  end

  always_comb begin
    in_ready         = (state_r == S_IDLE);
    out_valid        = (state_r == S_DONE);
    out_result_value = res_r;
    out_status       = st_r;
  end
endmodule
`default_nettype wire
